### design/cblc_pkg.sv
package cblc_pkg;

  localparam int NUM_LEDS_DEF = 3;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_BLINK_INTERVAL = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXCLUSIVE_PAIR = 4'd1;

  localparam logic [15:0] BLINK_INTERVAL_RST = 16'd500;
  localparam logic        EXCLUSIVE_PAIR_RST = 1'b1;

  localparam logic [2:0] MODE_TICK    = 3'd0;
  localparam logic [2:0] MODE_ON      = 3'd1;
  localparam logic [2:0] MODE_OFF     = 3'd2;
  localparam logic [2:0] MODE_BLINK   = 3'd3;
  localparam logic [2:0] MODE_ALL_ON  = 3'd4;
  localparam logic [2:0] MODE_ALL_OFF = 3'd5;

  typedef enum logic [2:0] {
    CH_OFF   = 3'b001,
    CH_ON    = 3'b010,
    CH_BLINK = 3'b100
  } ch_mode_t;

  typedef struct packed {
    logic       tick;
    logic       set_on;
    logic       set_off;
    logic       blink;
    logic [7:0] count;
  } ch_cmd_t;

endpackage

### design/cblc_channel.sv
module cblc_channel (
  input  logic             clk,
  input  logic             rst_n,
  input  cblc_pkg::ch_cmd_t cmd,
  input  logic [15:0]      interval,
  output logic             level_nxt_o,
  output logic             blink_nxt_o
);
  import cblc_pkg::*;

  ch_mode_t    mode_r, mode_nxt;
  logic        level_r, level_nxt;
  logic [8:0]  toggles_r, toggles_nxt;
  logic [15:0] elapsed_r, elapsed_nxt;
  logic [15:0] elapsed_inc;
  logic [8:0]  toggles_dec;

  assign elapsed_inc = (elapsed_r == 16'hffff) ? elapsed_r : elapsed_r + 16'd1;
  assign toggles_dec = toggles_r - 9'd1;

  always_comb begin
    mode_nxt    = mode_r;
    level_nxt   = level_r;
    toggles_nxt = toggles_r;
    elapsed_nxt = elapsed_r;
    if (cmd.blink) begin
      mode_nxt    = CH_BLINK;
      level_nxt   = 1'b1;
      toggles_nxt = {cmd.count, 1'b0} - 9'd1;
      elapsed_nxt = 16'd0;
    end else if (cmd.set_on) begin
      mode_nxt  = CH_ON;
      level_nxt = 1'b1;
    end else if (cmd.set_off) begin
      mode_nxt  = CH_OFF;
      level_nxt = 1'b0;
    end else if (cmd.tick && mode_r == CH_BLINK) begin
      elapsed_nxt = elapsed_inc;
      if (elapsed_inc >= interval) begin
        level_nxt   = ~level_r;
        elapsed_nxt = 16'd0;
        if (toggles_r != 9'd0) begin
          toggles_nxt = toggles_dec;
          if (toggles_dec == 9'd0) begin
            mode_nxt  = CH_OFF;
            level_nxt = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= CH_OFF;
      level_r   <= 1'b0;
      toggles_r <= 9'd0;
      elapsed_r <= 16'd0;
    end else begin
      mode_r    <= mode_nxt;
      level_r   <= level_nxt;
      toggles_r <= toggles_nxt;
      elapsed_r <= elapsed_nxt;
    end
  end

  assign level_nxt_o = level_nxt;
  assign blink_nxt_o = (mode_nxt == CH_BLINK);

endmodule

### design/counted_led_blink_controller.sv
// an accepted input item passes through the input register, then the result register,
// before its result can be accepted
// throughput: one item per cycle while results are accepted, set by the channel update between the registers
// a waiting result stalls the input only once the input register also holds an item
// reset: synchronous, active low; all channels off, interval 500, exclusive pair enabled
module counted_led_blink_controller #(
  parameter int NUM_LEDS = cblc_pkg::NUM_LEDS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [15:0]                    in_tdata,  // led_index[1:0], blink_count[9:2]
  input  logic [2:0]                     in_tuser,  // mode[2:0]
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [7:0]                     out_tdata, // led_levels[2:0], blinking_mask[5:3]
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [cblc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cblc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import cblc_pkg::*;

  logic        in_valid_r, in_valid_nxt;
  logic [2:0]  in_mode_r;
  logic [1:0]  in_idx_r;
  logic [7:0]  in_count_r;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_data_r;
  logic [15:0] interval_r;
  logic        excl_r;
  logic        advance, fire, idx_ok;
  logic [NUM_LEDS-1:0] lv_nxt, bm_nxt;
  ch_cmd_t     cmd [NUM_LEDS];

  assign advance   = !out_valid_r || out_tready;
  assign fire      = in_valid_r && advance;
  assign in_tready = !in_valid_r || advance;
  assign cfg_ready = 1'b1;
  assign idx_ok    = (32'(in_idx_r) < NUM_LEDS);

  assign in_valid_nxt  = (in_tvalid && in_tready) ? 1'b1 : (fire ? 1'b0 : in_valid_r);
  assign out_valid_nxt = fire ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  for (genvar i = 0; i < NUM_LEDS; i++) begin : g_ch
    logic sel, excl_off;
    assign sel      = idx_ok && (32'(in_idx_r) == i);
    assign excl_off = excl_r && idx_ok && (in_mode_r == MODE_ON) &&
                      (((in_idx_r == 2'd1) && (i == 2)) || ((in_idx_r == 2'd2) && (i == 1)));
    always_comb begin
      cmd[i].tick    = fire && (in_mode_r == MODE_TICK);
      cmd[i].set_on  = fire && (((in_mode_r == MODE_ON) && sel) || (in_mode_r == MODE_ALL_ON));
      cmd[i].set_off = fire && (((in_mode_r == MODE_OFF) && sel) ||
                                (in_mode_r == MODE_ALL_OFF) || excl_off);
      cmd[i].blink   = fire && (in_mode_r == MODE_BLINK) && sel && (in_count_r != 8'd0);
      cmd[i].count   = in_count_r;
    end
    cblc_channel u_channel (
      .clk         (clk),
      .rst_n       (rst_n),
      .cmd         (cmd[i]),
      .interval    (interval_r),
      .level_nxt_o (lv_nxt[i]),
      .blink_nxt_o (bm_nxt[i])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      interval_r  <= BLINK_INTERVAL_RST;
      excl_r      <= EXCLUSIVE_PAIR_RST;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_BLINK_INTERVAL: interval_r <= cfg_data[15:0];
          CFG_EXCLUSIVE_PAIR: excl_r     <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_mode_r  <= in_tuser;
      in_idx_r   <= in_tdata[1:0];
      in_count_r <= in_tdata[9:2];
    end
    if (fire) begin
      out_data_r <= {2'b00, bm_nxt[2:0], lv_nxt[2:0]};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTHESIS
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && out_valid_r && !out_tready) |-> !in_tready)
    else $error("input taken while pipeline stalled");

  a_accept_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> in_valid_r)
    else $error("accepted item lost from input register");

  a_reset_clears_output: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_tvalid)
    else $error("processed item produced no result");
`endif

endmodule

### bench/tb_counted_led_blink_controller.sv
module tb_counted_led_blink_controller;
  import cblc_pkg::*;

  localparam int NUM_LEDS     = NUM_LEDS_DEF;
  localparam int LATENCY      = 2;
  localparam int HOLD_CYCLES  = 200;
  localparam int WATCHDOG_MAX = 5000;
  localparam int MAX_PRINTED  = 40;

  localparam logic [2:0] MODE_RSVD_6 = 3'd6;
  localparam logic [2:0] MODE_RSVD_7 = 3'd7;

  typedef struct packed {
    logic [2:0] mode;
    logic [1:0] idx;
    logic [7:0] cnt;
  } led_cmd_t;

  typedef struct packed {
    logic [2:0] levels;
    logic [2:0] mask;
  } led_status_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [15:0]           in_tdata;
  logic [2:0]            in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [7:0]            out_tdata;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  counted_led_blink_controller i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // predicted channel state and register copies
  ch_mode_t    ch_mode_q    [NUM_LEDS];
  logic        ch_level_q   [NUM_LEDS];
  logic [8:0]  ch_toggles_q [NUM_LEDS];
  logic [15:0] ch_elapsed_q [NUM_LEDS];
  logic [15:0] interval_q;
  logic        exclusive_q;

  led_cmd_t    cmd_queue[$];
  led_status_t status_queue[$];

  int unsigned tx_idle_pct;
  int unsigned rx_stall_pct;
  int unsigned hold_requests;
  int unsigned hold_served;
  int unsigned rx_hold_left;
  int unsigned idle_cycles;
  int unsigned err_count;
  int unsigned items_in;
  int unsigned results_checked;
  int unsigned reg_writes;
  logic        in_taken;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    if (err_count < MAX_PRINTED)
      $display("mismatch at result %0d: %s got %0h expected %0h",
               results_checked, what, got, want);
    err_count++;
  endtask

  function automatic void set_channel(int ch, ch_mode_t m);
    ch_mode_q[ch]  = m;
    ch_level_q[ch] = (m == CH_ON);
  endfunction

  function automatic led_status_t advance_leds(led_cmd_t c);
    led_status_t r;
    logic        ok;
    ok = (c.idx < NUM_LEDS);
    case (c.mode)
      MODE_TICK: begin
        for (int i = 0; i < NUM_LEDS; i++) begin
          if (ch_mode_q[i] == CH_BLINK) begin
            if (ch_elapsed_q[i] != 16'hFFFF) ch_elapsed_q[i] = ch_elapsed_q[i] + 16'd1;
            if (ch_elapsed_q[i] >= interval_q) begin
              ch_level_q[i]   = ~ch_level_q[i];
              ch_elapsed_q[i] = 16'd0;
              if (ch_toggles_q[i] != 9'd0) begin
                ch_toggles_q[i] = ch_toggles_q[i] - 9'd1;
                if (ch_toggles_q[i] == 9'd0) set_channel(i, CH_OFF);
              end
            end
          end
        end
      end
      MODE_ON: begin
        if (ok) begin
          if (exclusive_q) begin
            if (c.idx == 2'd1 && NUM_LEDS > 2) set_channel(2, CH_OFF);
            else if (c.idx == 2'd2) set_channel(1, CH_OFF);
          end
          set_channel(32'(c.idx), CH_ON);
        end
      end
      MODE_OFF: begin
        if (ok) set_channel(32'(c.idx), CH_OFF);
      end
      MODE_BLINK: begin
        if (ok && c.cnt != 8'd0) begin
          ch_mode_q[c.idx]    = CH_BLINK;
          ch_level_q[c.idx]   = 1'b1;
          ch_toggles_q[c.idx] = {c.cnt, 1'b0} - 9'd1;
          ch_elapsed_q[c.idx] = 16'd0;
        end
      end
      MODE_ALL_ON: begin
        for (int i = 0; i < NUM_LEDS; i++) set_channel(i, CH_ON);
      end
      MODE_ALL_OFF: begin
        for (int i = 0; i < NUM_LEDS; i++) set_channel(i, CH_OFF);
      end
      default: begin
      end
    endcase
    r = '0;
    for (int i = 0; i < NUM_LEDS && i < 3; i++) begin
      r.levels[i] = ch_level_q[i];
      r.mask[i]   = (ch_mode_q[i] == CH_BLINK);
    end
    return r;
  endfunction

  // sender
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_taken) begin
      if (cmd_queue.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        in_tvalid <= 1'b1;
        in_tuser  <= cmd_queue[0].mode;
        in_tdata  <= {6'd0, cmd_queue[0].cnt, cmd_queue[0].idx};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // input acceptance and prediction
  always @(posedge clk) begin
    in_taken <= rst_n && in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) begin
      void'(cmd_queue.pop_front());
      status_queue.push_back(advance_leds(led_cmd_t'{mode: in_tuser, idx: in_tdata[1:0],
                                                     cnt: in_tdata[9:2]}));
      items_in++;
    end
  end

  // receiver, with long hold-offs on request
  always @(negedge clk) begin
    if (rx_hold_left != 0) begin
      out_tready   <= 1'b0;
      rx_hold_left <= rx_hold_left - 1;
    end else if (hold_requests != hold_served) begin
      out_tready   <= 1'b0;
      rx_hold_left <= HOLD_CYCLES;
      hold_served  <= hold_served + 1;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // result checking
  always @(posedge clk) begin
    led_status_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (status_queue.size() == 0) begin
        report_mismatch("unexpected item, tdata", 32'(out_tdata), 0);
      end else begin
        want = status_queue.pop_front();
        if (out_tdata[2:0] != want.levels)
          report_mismatch("led_levels", 32'(out_tdata[2:0]), 32'(want.levels));
        if (out_tdata[5:3] != want.mask)
          report_mismatch("blinking_mask", 32'(out_tdata[5:3]), 32'(want.mask));
      end
      results_checked++;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_MAX) begin
        $display("watchdog: no handshake for %0d cycles", idle_cycles);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic push_cmd(input logic [2:0] mode, input logic [1:0] idx,
                          input logic [7:0] cnt);
    cmd_queue.push_back(led_cmd_t'{mode: mode, idx: idx, cnt: cnt});
  endtask

  task automatic push_ticks(input int n);
    repeat (n) push_cmd(MODE_TICK, 2'($urandom), 8'($urandom));
  endtask

  task automatic wait_drained();
    while (cmd_queue.size() != 0 || status_queue.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_BLINK_INTERVAL) interval_q = val;
    else if (idx == CFG_EXCLUSIVE_PAIR) exclusive_q = val[0];
    reg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // mostly blink commands followed by tick runs, plus single commands and noise
  task automatic push_random(input int n);
    int          pushed;
    int unsigned r;
    int          run;
    logic [7:0]  cnt;
    pushed = 0;
    while (pushed < n) begin
      r = $urandom_range(99);
      if (r < 35) begin
        cnt = ($urandom_range(4) == 0) ? 8'($urandom_range(255, 1)) : 8'($urandom_range(3, 1));
        push_cmd(MODE_BLINK, 2'($urandom_range(NUM_LEDS - 1)), cnt);
        run = (interval_q > 8) ? $urandom_range(8, 1)
                               : $urandom_range(3 * (interval_q + 1) * cnt, 1);
        if (run > 30) run = 30;
        push_ticks(run);
        pushed += run + 1;
      end else begin
        if (r < 55) push_cmd(MODE_TICK, 2'($urandom), 8'($urandom));
        else if (r < 66) push_cmd(MODE_ON, 2'($urandom), 8'($urandom));
        else if (r < 74) push_cmd(MODE_OFF, 2'($urandom), 8'($urandom));
        else if (r < 78) push_cmd(MODE_ALL_ON, 2'($urandom), 8'($urandom));
        else if (r < 82) push_cmd(MODE_ALL_OFF, 2'($urandom), 8'($urandom));
        else if (r < 87) push_cmd(($urandom_range(1) != 0) ? MODE_RSVD_6 : MODE_RSVD_7,
                                  2'($urandom), 8'($urandom));
        else if (r < 93) push_cmd(MODE_BLINK, 2'($urandom), 8'd0);
        else push_cmd(($urandom_range(2) == 0) ? MODE_ON :
                      (($urandom_range(1) == 0) ? MODE_OFF : MODE_BLINK),
                      2'd3, 8'($urandom));
        pushed++;
      end
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    in_tuser      = '0;
    out_tready    = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    in_taken      = 1'b0;
    tx_idle_pct   = 0;
    rx_stall_pct  = 0;
    hold_requests = 0;
    hold_served   = 0;
    rx_hold_left  = 0;
    idle_cycles   = 0;
    err_count     = 0;
    items_in      = 0;
    results_checked = 0;
    reg_writes    = 0;
    interval_q    = BLINK_INTERVAL_RST;
    exclusive_q   = EXCLUSIVE_PAIR_RST;
    for (int i = 0; i < NUM_LEDS; i++) begin
      ch_mode_q[i]    = CH_OFF;
      ch_level_q[i]   = 1'b0;
      ch_toggles_q[i] = 9'd0;
      ch_elapsed_q[i] = 16'd0;
    end
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset settings, no idling: every mode, exclusivity, ignored commands
    push_cmd(MODE_TICK, 2'd0, 8'd0);
    push_cmd(MODE_ON, 2'd0, 8'd0);
    push_cmd(MODE_ON, 2'd1, 8'd0);
    push_cmd(MODE_ON, 2'd2, 8'd0);
    push_cmd(MODE_ON, 2'd1, 8'hFF);
    push_cmd(MODE_OFF, 2'd1, 8'd0);
    push_cmd(MODE_ON, 2'd3, 8'd0);
    push_cmd(MODE_OFF, 2'd3, 8'd0);
    push_cmd(MODE_BLINK, 2'd3, 8'd7);
    push_cmd(MODE_BLINK, 2'd0, 8'd0);
    push_cmd(MODE_BLINK, 2'd0, 8'd255);
    push_cmd(MODE_BLINK, 2'd1, 8'd1);
    push_cmd(MODE_TICK, 2'd3, 8'hFF);
    push_cmd(MODE_BLINK, 2'd0, 8'd2);
    push_cmd(MODE_RSVD_6, 2'd2, 8'hAA);
    push_cmd(MODE_RSVD_7, 2'd1, 8'h55);
    push_cmd(MODE_ALL_ON, 2'd0, 8'd0);
    push_cmd(MODE_OFF, 2'd0, 8'd0);
    push_cmd(MODE_ALL_OFF, 2'd0, 8'd0);
    push_cmd(MODE_BLINK, 2'd2, 8'd200);
    push_cmd(MODE_ALL_ON, 2'd0, 8'd0);
    push_cmd(MODE_TICK, 2'd0, 8'd0);
    wait_drained();

    // zero interval, no exclusivity: toggle on every tick, largest blink count
    write_reg(CFG_BLINK_INTERVAL, 16'd0);
    write_reg(CFG_EXCLUSIVE_PAIR, 16'd0);
    push_cmd(MODE_ON, 2'd1, 8'd0);
    push_cmd(MODE_ON, 2'd2, 8'd0);
    push_cmd(MODE_BLINK, 2'd0, 8'd1);
    push_ticks(2);
    push_cmd(MODE_BLINK, 2'd0, 8'd255);
    push_ticks(40);
    push_random(60);
    wait_drained();

    // sender idle most of the time
    tx_idle_pct = 75;
    write_reg(CFG_BLINK_INTERVAL, 16'd1);
    write_reg(CFG_EXCLUSIVE_PAIR, 16'd1);
    push_random(60);
    wait_drained();

    // largest interval while blinking, then shrink it under running channels
    tx_idle_pct  = 0;
    rx_stall_pct = 75;
    write_reg(CFG_BLINK_INTERVAL, 16'hFFFF);
    push_cmd(MODE_BLINK, 2'd0, 8'd3);
    push_cmd(MODE_BLINK, 2'd1, 8'd1);
    push_ticks(10);
    push_random(20);
    wait_drained();
    write_reg(CFG_BLINK_INTERVAL, 16'd2);
    push_ticks(20);
    push_random(50);
    wait_drained();

    // both sides idling
    tx_idle_pct  = 29;
    rx_stall_pct = 29;
    write_reg(CFG_BLINK_INTERVAL, 16'd3);
    write_reg(CFG_EXCLUSIVE_PAIR, 16'd0);
    push_random(60);
    wait_drained();

    // long receiver hold-off while the sender keeps offering, then a pause
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    write_reg(CFG_BLINK_INTERVAL, 16'd2);
    write_reg(CFG_EXCLUSIVE_PAIR, 16'd1);
    hold_requests++;
    push_random(40);
    wait_drained();
    push_random(40);
    wait_drained();

    tx_idle_pct  = 29;
    rx_stall_pct = 29;
    write_reg(CFG_BLINK_INTERVAL, 16'($urandom_range(4)));
    write_reg(CFG_EXCLUSIVE_PAIR, 16'($urandom_range(1)));
    push_random(60);
    wait_drained();
    repeat (LATENCY + 8) @(posedge clk);

    $display("covered %0d items and %0d checked results over %0d register writes",
             items_in, results_checked, reg_writes);
    $display("intervals 0 to 65535, exclusivity on and off, idle mixes and a long hold-off");
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatches", err_count);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
